// ===== sv/aisenc_pkg.sv =====
package aisenc_pkg;

  localparam int PayloadBits  = 168;
  localparam int CharBits     = 6;

  typedef logic [5:0] pos_t;

  // character positions within the sentence
  localparam pos_t POS_CHANNEL   = 6'd12;
  localparam pos_t POS_PAY_FIRST = 6'd14;
  localparam pos_t POS_PAY_LAST  = 6'd41;
  localparam pos_t POS_COMMA     = 6'd42;
  localparam pos_t POS_ZERO      = 6'd43;
  localparam pos_t POS_STAR      = 6'd44;
  localparam pos_t POS_HEX_HI    = 6'd45;
  localparam pos_t POS_HEX_LO    = 6'd46;
  localparam pos_t POS_CR        = 6'd47;
  localparam pos_t POS_LF        = 6'd48;

  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_A      = 8'h41;
  localparam logic [7:0] CH_B      = 8'h42;

  localparam logic [5:0] MSG_ID        = 6'd1;
  localparam logic [8:0] HEADING_NA    = 9'd511;
  localparam logic [2:0] SLOT_TIMEOUT  = 3'd1;

  localparam logic [2:0] ADDR_RADIO_CHANNEL = 3'd0;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic at_last;
  } status_t;

  // fixed sentence head "$AIVDM,1,1,,A," (channel letter patched by caller)
  function automatic logic [7:0] head_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = 8'h24;
      4'd1:    c = 8'h41;
      4'd2:    c = 8'h49;
      4'd3:    c = 8'h56;
      4'd4:    c = 8'h44;
      4'd5:    c = 8'h4D;
      4'd6:    c = CH_COMMA;
      4'd7:    c = 8'h31;
      4'd8:    c = CH_COMMA;
      4'd9:    c = 8'h31;
      4'd10:   c = CH_COMMA;
      4'd11:   c = CH_COMMA;
      4'd12:   c = CH_A;
      4'd13:   c = CH_COMMA;
      default: c = CH_COMMA;
    endcase
    return c;
  endfunction

  // six-bit value to payload character, skipping the gap after 'W'
  function automatic logic [7:0] armor(input logic [5:0] v);
    return (v < 6'd40) ? ({2'b00, v} + 8'd48) : ({2'b00, v} + 8'd56);
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    return (nib < 4'd10) ? ({4'h0, nib} + 8'h30) : ({4'h0, nib} + 8'h37);
  endfunction

endpackage

// ===== sv/aisenc_ctrl.sv =====
module aisenc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  aisenc_pkg::status_t status,
  output aisenc_pkg::cmd_t    cmd
);
  import aisenc_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.step = 1'b1;
          if (status.at_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// ===== sv/aisenc_dp.sv =====
module aisenc_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  aisenc_pkg::cmd_t    cmd,
  output aisenc_pkg::status_t status,
  input  logic                radio_channel,
  input  logic [1:0]          repeat_count,
  input  logic [29:0]         vessel_id,
  input  logic [3:0]          navigation_status,
  input  logic signed [7:0]   turn_rate,
  input  logic [9:0]          ground_speed,
  input  logic                position_accurate,
  input  logic signed [27:0]  longitude_value,
  input  logic signed [26:0]  latitude_value,
  input  logic [11:0]         ground_course,
  input  logic [5:0]          utc_second,
  input  logic [4:0]          utc_hour,
  input  logic [5:0]          utc_minute,
  input  logic                out_stall,
  output logic                out_valid,
  output logic [7:0]          text_byte,
  output logic                last_byte
);
  import aisenc_pkg::*;

  logic [PayloadBits-1:0] payload_r, payload_nxt;
  pos_t                   pos_r;
  logic [7:0]             xor_r;
  logic                   out_valid_r;
  logic [7:0]             byte_r;
  logic                   last_r;
  logic [7:0]             cur_byte;
  logic                   in_payload;
  logic                   in_sum;

  always_comb begin
    payload_nxt = {MSG_ID, repeat_count, vessel_id, navigation_status, turn_rate,
                   ground_speed, position_accurate, longitude_value, latitude_value,
                   ground_course, HEADING_NA, utc_second,
                   2'b00, 3'b000, 1'b0,            // maneuver, spare, RAIM
                   2'b00, SLOT_TIMEOUT, utc_hour,  // sync state, timeout, hour
                   1'b0, utc_minute, 2'b00};
  end

  assign in_payload = (pos_r >= POS_PAY_FIRST) && (pos_r <= POS_PAY_LAST);
  // checksum covers everything between '$' and '*'
  assign in_sum     = (pos_r != 6'd0) && (pos_r < POS_STAR);

  always_comb begin
    case (pos_r) inside
      [6'd0:6'd13]: begin
        cur_byte = head_char(pos_r[3:0]);
        if (pos_r == POS_CHANNEL) begin
          cur_byte = radio_channel ? CH_B : CH_A;
        end
      end
      [POS_PAY_FIRST:POS_PAY_LAST]:
                  cur_byte = armor(payload_r[PayloadBits-1 -: CharBits]);
      POS_COMMA:  cur_byte = CH_COMMA;
      POS_ZERO:   cur_byte = CH_ZERO;
      POS_STAR:   cur_byte = CH_STAR;
      POS_HEX_HI: cur_byte = hex_char(xor_r[7:4]);
      POS_HEX_LO: cur_byte = hex_char(xor_r[3:0]);
      POS_CR:     cur_byte = CH_CR;
      POS_LF:     cur_byte = CH_LF;
      default:    cur_byte = CH_LF;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (cmd.load) begin
      pos_r <= '0;
      if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end else if (cmd.step) begin
      pos_r       <= pos_r + 6'd1;
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      payload_r <= payload_nxt;
      xor_r     <= '0;
    end else if (cmd.step) begin
      byte_r <= cur_byte;
      last_r <= (pos_r == POS_LF);
      if (in_payload) begin
        payload_r <= {payload_r[PayloadBits-CharBits-1:0], {CharBits{1'b0}}};
      end
      if (in_sum) begin
        xor_r <= xor_r ^ cur_byte;
      end
    end
  end

  assign status.out_free = !out_valid_r || !out_stall;
  assign status.at_last  = (pos_r == POS_LF);
  assign out_valid       = out_valid_r;
  assign text_byte       = byte_r;
  assign last_byte       = last_r;

endmodule

// ===== sv/ais_position_report_sentence_encoder_core.sv =====
// channel | direction | handshake          | payload
// in      | input     | in_valid/in_stall  | position report fields
// out     | output    | out_valid/out_stall| out_text_byte, out_last_byte
// cfg     | input     | APB-style          | radio_channel at byte address 0
//
// A request is taken only while idle; it then yields 49 bytes from the single output
// register, one per cycle while out_stall does not hold the output.
// The byte sequencer steps one character position per cycle when not stalled.
// out_stall freezes the sequencer with the current byte held on the output.
// The next request is taken once the line feed is loaded into the output register.
// rst_n is synchronous; reset empties the output and sets the channel to A.
module ais_position_report_sentence_encoder_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          in_repeat_count,
  input  logic [29:0]         in_vessel_id,
  input  logic [3:0]          in_navigation_status,
  input  logic signed [7:0]   in_turn_rate,
  input  logic [9:0]          in_ground_speed,
  input  logic                in_position_accurate,
  input  logic signed [27:0]  in_longitude_value,
  input  logic signed [26:0]  in_latitude_value,
  input  logic [11:0]         in_ground_course,
  input  logic [5:0]          in_utc_second,
  input  logic [4:0]          in_utc_hour,
  input  logic [5:0]          in_utc_minute,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          out_text_byte,
  output logic                out_last_byte,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [2:0]          cfg_paddr,
  input  logic [31:0]         cfg_pwdata,
  output logic [31:0]         cfg_prdata,
  output logic                cfg_pready
);
  import aisenc_pkg::*;

  cmd_t    cmd;
  status_t status;
  logic    radio_channel_r;
  logic    cfg_hit;

  assign cfg_pready = 1'b1;
  assign cfg_hit    = (cfg_paddr[2] == ADDR_RADIO_CHANNEL[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radio_channel_r <= 1'b0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_hit) begin
      radio_channel_r <= cfg_pwdata[0];
    end
  end

  assign cfg_prdata = cfg_hit ? {31'd0, radio_channel_r} : 32'd0;

  aisenc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  aisenc_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .status            (status),
    .radio_channel     (radio_channel_r),
    .repeat_count      (in_repeat_count),
    .vessel_id         (in_vessel_id),
    .navigation_status (in_navigation_status),
    .turn_rate         (in_turn_rate),
    .ground_speed      (in_ground_speed),
    .position_accurate (in_position_accurate),
    .longitude_value   (in_longitude_value),
    .latitude_value    (in_latitude_value),
    .ground_course     (in_ground_course),
    .utc_second        (in_utc_second),
    .utc_hour          (in_utc_hour),
    .utc_minute        (in_utc_minute),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .text_byte         (out_text_byte),
    .last_byte         (out_last_byte)
  );

`ifndef ASSERT_OFF
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request accepted but encoder not busy");

  a_last_is_lf: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_byte |-> out_text_byte == CH_LF)
    else $error("last byte is not a line feed");

  a_idle_holds_only_last: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> !out_valid || out_last_byte)
    else $error("idle with a sentence byte other than the last pending");
`endif

endmodule
